>>> hdl/stt_pkg.sv
// ----------------------------------------------------------------------------
// Search transposition table package
// Shared sizes, payload layouts, codes and state encoding.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int unsigned TableEntries = 65536;
  localparam int unsigned IdxW         = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam bit          IdxPow2      = (TableEntries & (TableEntries - 1)) == 0;
  localparam bit          IdxWide      = TableEntries > 65536;

  // Reciprocal for slot reduction when the table size is not a power of two
  localparam longint unsigned RecipS = 64'(16 + IdxW);
  localparam longint unsigned RecipM =
    ((64'd1 << RecipS) + 64'(TableEntries) - 64'd1) / 64'(TableEntries);

  localparam int unsigned DepthMargin = 4;

  localparam int unsigned InDataW  = 136;
  localparam int unsigned OutDataW = 72;

  localparam logic signed [15:0] WinReset  = 16'sd31000;
  localparam logic signed [15:0] LossReset = -16'sd31000;

  typedef enum logic [1:0] {
    BoundNone  = 2'd0,
    BoundLow   = 2'd1,
    BoundHigh  = 2'd2,
    BoundExact = 2'd3
  } bound_e;

  typedef enum logic [0:0] {
    CfgWin  = 1'b0,
    CfgLoss = 1'b1
  } cfg_idx_e;

  typedef enum logic [0:0] {
    OpProbe  = 1'b0,
    OpInsert = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    StClear = 4'b0001,
    StIdle  = 4'b0010,
    StAddr  = 4'b0100,
    StLook  = 4'b1000
  } state_e;

  // Input item, last declared field in the lowest bits
  typedef struct packed {
    logic [15:0] beta;
    logic [15:0] alpha;
    logic [1:0]  bound_in;
    logic [5:0]  age_in;
    logic [7:0]  ply_count;
    logic [7:0]  depth_in;
    logic [15:0] eval_in;
    logic [15:0] search_score;
    logic [15:0] move_code;
    logic [15:0] key;
    logic [15:0] slot;
  } in_data_t;

  // Result item, last declared field in the lowest bits
  typedef struct packed {
    logic [4:0]  pad;
    logic        score_usable;
    logic [15:0] root_score;
    logic [15:0] eval_out;
    logic [15:0] move_out;
    logic [7:0]  depth_out;
    logic [5:0]  age_out;
    logic [1:0]  bound_out;
    logic        stored;
    logic        key_hit;
  } out_data_t;

  typedef struct packed {
    logic [15:0] eval_v;
    logic [15:0] score;
    logic [15:0] move;
    logic [15:0] key;
  } entry_main_t;

  typedef struct packed {
    logic [5:0] age;
    logic [1:0] bound;
    logic [7:0] depth;
  } entry_meta_t;

endpackage

>>> hdl/stt_ram.sv
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module stt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/search_transposition_table_top.sv
// ----------------------------------------------------------------------------
// Search transposition table
// Direct-mapped table of search results with depth-preferred replacement.
// ----------------------------------------------------------------------------
//  channel   | direction | payload
//  s_axis    | in        | tuser: operation; tdata: slot .. beta (136 bits)
//  m_axis    | out       | tdata: key_hit .. score_usable (72 bits)
//  cfg       | in        | cfg_addr_i register index, cfg_data_i 16-bit value
//
//  The result is registered in the update and write-back state, after the
//  slot reduction and table read state; the next item is taken in the
//  write-back cycle, so an item is accepted only once the last has ended
//  the single read-write pass.
//  After reset the table is swept to zero, one entry a cycle over all
//  TableEntries entries, with s_axis_tready_o low; configuration writes are taken throughout.
//  A stalled result holds the last stage and the input side.
// ----------------------------------------------------------------------------
module search_transposition_table_top
  import stt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // slot, key, move_code, search_score, eval_in, depth_in, ply_count, age_in,
  // bound_in, alpha, beta
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // operation
  input  logic [0:0]          s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // key_hit, stored, bound_out, age_out, depth_out, move_out, eval_out,
  // root_score, score_usable, zero padding
  output logic [OutDataW-1:0] m_axis_tdata_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [0:0]          cfg_addr_i,
  input  logic [15:0]         cfg_data_i
);

  state_e            state_q, state_d;
  logic [IdxW-1:0]   clr_q, clr_d;
  in_data_t          in_q;
  op_e               op_q;
  logic [15:0]       quot_q, quot_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic signed [15:0] win_q, loss_q;
  out_data_t         out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic              in_acc;
  logic              out_free;
  logic              finish;
  logic [32:0]       prod;
  in_data_t          in_new;

  entry_main_t       main_rd, main_wr, main_new;
  entry_meta_t       meta_rd, meta_wr, meta_new;
  logic              main_we, meta_re;
  logic [IdxW-1:0]   wr_addr;
  logic              wrote;

  // Configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= WinReset;
      loss_q <= LossReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CfgWin:  win_q  <= $signed(cfg_data_i);
        CfgLoss: loss_q <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Handshake
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign finish          = (state_q == StLook) && out_free;
  assign s_axis_tready_o = (state_q == StIdle) || finish;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign in_new          = in_data_t'(s_axis_tdata_i);

  // Slot reduction
  assign prod = 33'(in_new.slot) * 33'(17'(RecipM));

  always_comb begin
    if (IdxPow2 || IdxWide) begin
      quot_d = '0;
      idx_d  = IdxW'(in_q.slot);
    end else begin
      quot_d = 16'(prod >> RecipS);
      idx_d  = IdxW'(in_q.slot - 16'(quot_q * 16'(TableEntries)));
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    unique case (state_q)
      StClear: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == IdxW'(TableEntries - 1)) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_acc) state_d = StAddr;
      end
      StAddr: state_d = StLook;
      StLook: begin
        if (finish) state_d = in_acc ? StAddr : StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q   <= in_new;
      op_q   <= op_e'(s_axis_tuser_i);
      quot_q <= quot_d;
    end
    if (state_q == StAddr) begin
      idx_q <= idx_d;
    end
  end

  // Table memories
  assign meta_re = (state_q == StAddr);

  stt_ram #(.Width(64), .Depth(TableEntries)) u_main_ram (
    .clk_i  (clk_i),
    .we_i   (main_we),
    .waddr_i(wr_addr),
    .wdata_i(main_wr),
    .re_i   (meta_re),
    .raddr_i(idx_d),
    .rdata_o(main_rd)
  );

  stt_ram #(.Width(16), .Depth(TableEntries)) u_meta_ram (
    .clk_i  (clk_i),
    .we_i   (main_we),
    .waddr_i(wr_addr),
    .wdata_i(meta_wr),
    .re_i   (meta_re),
    .raddr_i(idx_d),
    .rdata_o(meta_rd)
  );

  // Update and result
  always_comb begin
    logic              hit;
    logic              skip;
    logic signed [9:0] dep_new;
    logic signed [9:0] dep_lim;
    logic signed [15:0] sc;
    logic signed [15:0] ss;
    logic [15:0]       ply16;
    entry_main_t       main_res;
    entry_meta_t       meta_res;

    ply16   = {8'd0, in_q.ply_count};
    hit     = main_rd.key == in_q.key;
    dep_new = $signed({2'b00, in_q.depth_in});
    dep_lim = $signed({2'b00, meta_rd.depth}) - 10'(DepthMargin);
    skip    = hit && (bound_e'(in_q.bound_in) != BoundExact) && (dep_new <= dep_lim);
    wrote   = (op_q == OpInsert) && !skip;

    sc = $signed(in_q.search_score);
    if (sc >= win_q) begin
      main_new.score = in_q.search_score + ply16;
    end else if (sc <= loss_q) begin
      main_new.score = in_q.search_score - ply16;
    end else begin
      main_new.score = in_q.search_score;
    end
    main_new.key    = in_q.key;
    main_new.move   = (bound_e'(in_q.bound_in) != BoundLow) ? in_q.move_code : main_rd.move;
    main_new.eval_v = in_q.eval_in;
    meta_new.depth  = in_q.depth_in;
    meta_new.bound  = in_q.bound_in;
    meta_new.age    = in_q.age_in;

    main_res = wrote ? main_new : main_rd;
    meta_res = wrote ? meta_new : meta_rd;

    ss = $signed(main_res.score);
    out_d.pad       = '0;
    out_d.key_hit   = hit;
    out_d.stored    = wrote;
    out_d.bound_out = meta_res.bound;
    out_d.age_out   = meta_res.age;
    out_d.depth_out = meta_res.depth;
    out_d.move_out  = main_res.move;
    out_d.eval_out  = main_res.eval_v;
    if (ss <= loss_q) begin
      out_d.root_score = main_res.score + ply16;
    end else if (ss >= win_q) begin
      out_d.root_score = main_res.score - ply16;
    end else begin
      out_d.root_score = main_res.score;
    end
    out_d.score_usable =
      ((bound_e'(meta_res.bound) == BoundLow) && (ss <= $signed(in_q.alpha))) ||
      ((bound_e'(meta_res.bound) == BoundHigh) && (ss >= $signed(in_q.beta))) ||
      (bound_e'(meta_res.bound) == BoundExact);
  end

  always_comb begin
    if (state_q == StClear) begin
      main_we = 1'b1;
      wr_addr = clr_q;
      main_wr = '0;
      meta_wr = '0;
    end else begin
      main_we = finish && wrote;
      wr_addr = idx_q;
      main_wr = main_new;
      meta_wr = meta_new;
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (finish) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

endmodule

>>> hdl/stt_checker.sv
// ----------------------------------------------------------------------------
// Search transposition table checker
// Port-level properties of the top level, attached by bind.
// ----------------------------------------------------------------------------
module stt_checker
  import stt_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid_i,
  input logic                s_axis_tready_o,
  input logic                m_axis_tvalid_o,
  input logic                m_axis_tready_i,
  input logic [OutDataW-1:0] m_axis_tdata_o
);

  out_data_t res;
  logic      in_acc;

  assign res    = out_data_t'(m_axis_tdata_o);
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;

  // Stalled result transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // A fresh result follows an accepted input transaction
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(in_acc, 3))
    else $error("result without a preceding input transaction");

  a_exact_usable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (bound_e'(res.bound_out) == BoundExact) |-> res.score_usable)
    else $error("exact bound not usable");

  a_none_unusable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (bound_e'(res.bound_out) == BoundNone) |-> !res.score_usable)
    else $error("empty bound marked usable");

endmodule

bind search_transposition_table_top stt_checker u_stt_checker (.*);
